/* src/bilinear_image_resize_unit_assert.svh */
// Assertion macros used by the bilinear resize RTL.
`ifndef BILINEAR_IMAGE_RESIZE_UNIT_ASSERT_SVH
`define BILINEAR_IMAGE_RESIZE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BIR_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bilinear resize check failed");

// Next-cycle implication, checked out of reset.
`define BIR_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bilinear resize check failed");

`endif

/* src/bir_pkg.sv */
// Package: constants, codes and types of the bilinear resize unit.
package bir_pkg;

  localparam int unsigned DEF_MAX_SOURCE_WIDTH  = 512;
  localparam int unsigned DEF_MAX_SOURCE_HEIGHT = 512;
  localparam int unsigned DEF_FRACTION_BITS     = 16;

  localparam int unsigned COORD_W    = 10;
  localparam int unsigned SRC_SIZE_W = 10;
  localparam int unsigned DST_SIZE_W = 11;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [SRC_SIZE_W-1:0] RST_SOURCE_WIDTH  = 10'd512;
  localparam logic [SRC_SIZE_W-1:0] RST_SOURCE_HEIGHT = 10'd512;
  localparam logic [DST_SIZE_W-1:0] RST_TARGET_WIDTH  = 11'd320;
  localparam logic [DST_SIZE_W-1:0] RST_TARGET_HEIGHT = 11'd320;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 3'd0,
    CFG_SOURCE_HEIGHT = 3'd1,
    CFG_TARGET_WIDTH  = 3'd2,
    CFG_TARGET_HEIGHT = 3'd3
  } cfg_index_t;

  typedef enum logic {
    OP_STORE   = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // Item fields carried down the pipeline
  typedef struct packed {
    op_t                op;
    logic               err;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    pixel_t             pix;
  } item_t;

endpackage

/* src/bilinear_image_resize_unit.sv */
// Top level: bilinear resize with frame store in four interleaved banks.
//
//  port group | direction | contents
//  in_*       | input     | op, col, row, blue/green/red of a source pixel
//  out_*      | output    | red/green/blue result, range_error flag
//  cfg_*      | input     | register write: cfg_we, cfg_index, cfg_data
//
// One item per cycle unless a stall on out_ready holds the pipeline. Stages: one
// input stage, one restoring-divider stage per quotient bit (10 + FRACTION_BITS), then address
// and weight, bank read, multiply and sum stages. Stores write the bank in the
// read stage, so they stay in order with requests. Reset (rst_n low, sync)
// clears valid bits and configuration registers; store contents stay
// undefined. A stall on out_ready freezes every stage; nothing is lost or repeated.
`include "bilinear_image_resize_unit_assert.svh"

module bilinear_image_resize_unit #(
  parameter int unsigned MAX_SOURCE_WIDTH  = bir_pkg::DEF_MAX_SOURCE_WIDTH,
  parameter int unsigned MAX_SOURCE_HEIGHT = bir_pkg::DEF_MAX_SOURCE_HEIGHT,
  parameter int unsigned FRACTION_BITS     = bir_pkg::DEF_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [bir_pkg::COORD_W-1:0]    in_col,
  input  logic [bir_pkg::COORD_W-1:0]    in_row,
  input  logic [bir_pkg::CHAN_W-1:0]     in_blue_in,
  input  logic [bir_pkg::CHAN_W-1:0]     in_green_in,
  input  logic [bir_pkg::CHAN_W-1:0]     in_red_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bir_pkg::CHAN_W-1:0]     out_red_out,
  output logic [bir_pkg::CHAN_W-1:0]     out_green_out,
  output logic [bir_pkg::CHAN_W-1:0]     out_blue_out,
  output logic                           out_range_error,
  input  logic                           cfg_we,
  input  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bir_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SW   = bir_pkg::SRC_SIZE_W;
  localparam int unsigned DW   = bir_pkg::DST_SIZE_W;
  localparam int unsigned CW   = bir_pkg::COORD_W;
  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned NUMW = CW + SW;
  localparam int unsigned DSTEPS = SW + F;
  localparam int unsigned WW   = 2 * F + 2;
  localparam int unsigned PW   = WW + bir_pkg::CHAN_W;
  localparam int unsigned SUMW = PW + 2;
  localparam int unsigned HALF_W = (MAX_SOURCE_WIDTH + 1) / 2;
  localparam int unsigned HALF_H = (MAX_SOURCE_HEIGHT + 1) / 2;
  localparam int unsigned BANK_DEPTH = HALF_W * HALF_H;
  localparam int unsigned BAW  = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned SW_LIM = (MAX_SOURCE_WIDTH  < 1023) ? MAX_SOURCE_WIDTH  : 1023;
  localparam int unsigned SH_LIM = (MAX_SOURCE_HEIGHT < 1023) ? MAX_SOURCE_HEIGHT : 1023;
  localparam logic [SW-1:0] SW_LIM_V = SW_LIM[SW-1:0];
  localparam logic [SW-1:0] SH_LIM_V = SH_LIM[SW-1:0];

  // Configuration registers
  logic [SW-1:0] src_w_r, src_h_r;
  logic [DW-1:0] dst_w_r, dst_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= bir_pkg::RST_SOURCE_WIDTH;
      src_h_r <= bir_pkg::RST_SOURCE_HEIGHT;
      dst_w_r <= bir_pkg::RST_TARGET_WIDTH;
      dst_h_r <= bir_pkg::RST_TARGET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bir_pkg::CFG_SOURCE_WIDTH:  src_w_r <= cfg_data[SW-1:0];
        bir_pkg::CFG_SOURCE_HEIGHT: src_h_r <= cfg_data[SW-1:0];
        bir_pkg::CFG_TARGET_WIDTH:  dst_w_r <= cfg_data[DW-1:0];
        bir_pkg::CFG_TARGET_HEIGHT: dst_h_r <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // Effective source size: zero as one, capped at the store size
  logic [SW-1:0] sw_c, sh_c, sw_m1, sh_m1;
  always_comb begin
    sw_c = (src_w_r == '0) ? SW'(1) : ((src_w_r > SW_LIM_V) ? SW_LIM_V : src_w_r);
    sh_c = (src_h_r == '0) ? SW'(1) : ((src_h_r > SH_LIM_V) ? SH_LIM_V : src_h_r);
    sw_m1 = sw_c - SW'(1);
    sh_m1 = sh_c - SW'(1);
  end

  // Whole pipeline moves when the output register is free or being taken
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // One restoring-division step: remainder and quotient/dividend shift word
  function automatic logic [DW+DSTEPS-1:0] div_step(
    input logic [DW-1:0] rem, input logic [DSTEPS-1:0] tq, input logic [DW-1:0] d
  );
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    t    = {rem, tq[DSTEPS-1]};
    diff = t - {1'b0, d};
    ge   = (t >= {1'b0, d});
    return {(ge ? diff[DW-1:0] : t[DW-1:0]), tq[DSTEPS-2:0], ge};
  endfunction

  function automatic logic [BAW-1:0] bank_addr(
    input logic [CW-1:0] r, input logic [CW-1:0] c
  );
    logic [31:0] a;
    a = 32'(r >> 1) * 32'(HALF_W) + 32'(c >> 1);
    return a[BAW-1:0];
  endfunction

  // Input and divider stages: index 0 is the input stage
  logic                 v_p_r    [0:DSTEPS];
  bir_pkg::item_t       item_p_r [0:DSTEPS];
  logic [DW-1:0]        remx_p_r [0:DSTEPS];
  logic [DW-1:0]        remy_p_r [0:DSTEPS];
  logic [DSTEPS-1:0]    tqx_p_r  [0:DSTEPS];
  logic [DSTEPS-1:0]    tqy_p_r  [0:DSTEPS];

  logic [NUMW-1:0] numx, numy;
  bir_pkg::item_t  in_item;
  always_comb begin
    numx = in_col * sw_c;
    numy = in_row * sh_c;
    in_item.op  = bir_pkg::op_t'(in_op);
    in_item.err = ({1'b0, in_col} >= dst_w_r) || ({1'b0, in_row} >= dst_h_r);
    in_item.col = in_col;
    in_item.row = in_row;
    in_item.pix = '{red: in_red_in, green: in_green_in, blue: in_blue_in};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_p_r[0] <= 1'b0;
    end else if (adv) begin
      v_p_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_p_r[0] <= in_item;
      remx_p_r[0] <= {1'b0, numx[NUMW-1:SW]};
      remy_p_r[0] <= {1'b0, numy[NUMW-1:SW]};
      tqx_p_r[0]  <= {numx[SW-1:0], {F{1'b0}}};
      tqy_p_r[0]  <= {numy[SW-1:0], {F{1'b0}}};
    end
  end

  for (genvar k = 1; k <= DSTEPS; k++) begin : g_div
    logic [DW+DSTEPS-1:0] sx, sy;
    assign sx = div_step(remx_p_r[k-1], tqx_p_r[k-1], dst_w_r);
    assign sy = div_step(remy_p_r[k-1], tqy_p_r[k-1], dst_h_r);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_p_r[k] <= 1'b0;
      end else if (adv) begin
        v_p_r[k] <= v_p_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        item_p_r[k] <= item_p_r[k-1];
        remx_p_r[k] <= sx[DW+DSTEPS-1:DSTEPS];
        remy_p_r[k] <= sy[DW+DSTEPS-1:DSTEPS];
        tqx_p_r[k]  <= sx[DSTEPS-1:0];
        tqy_p_r[k]  <= sy[DSTEPS-1:0];
      end
    end
  end

  // Address and weight stage
  logic [CW-1:0] x0, x1, y0, y1, xq, yq;
  logic [F-1:0]  fx, fy;
  logic [F:0]    ofx, ofy;
  logic [WW-1:0] w_nxt [4];
  logic [BAW-1:0] addr_nxt [4];
  logic [1:0]    sel_nxt [4];
  logic          we_nxt;
  bir_pkg::item_t it_d;

  always_comb begin
    it_d = item_p_r[DSTEPS];
    xq = tqx_p_r[DSTEPS][DSTEPS-1:F];
    yq = tqy_p_r[DSTEPS][DSTEPS-1:F];
    fx = tqx_p_r[DSTEPS][F-1:0];
    fy = tqy_p_r[DSTEPS][F-1:0];
    x0 = (xq > sw_m1) ? sw_m1 : xq;
    y0 = (yq > sh_m1) ? sh_m1 : yq;
    x1 = (x0 < sw_m1) ? x0 + CW'(1) : x0;
    y1 = (y0 < sh_m1) ? y0 + CW'(1) : y0;
    ofx = {1'b1, {F{1'b0}}} - {1'b0, fx};
    ofy = {1'b1, {F{1'b0}}} - {1'b0, fy};
    w_nxt[0] = ofx * ofy;
    w_nxt[1] = {1'b0, fx} * ofy;
    w_nxt[2] = ofx * {1'b0, fy};
    w_nxt[3] = {1'b0, fx} * {1'b0, fy};
    // neighbor order: top-left, top-right, bottom-left, bottom-right
    sel_nxt[0] = {y0[0], x0[0]};
    sel_nxt[1] = {y0[0], x1[0]};
    sel_nxt[2] = {y1[0], x0[0]};
    sel_nxt[3] = {y1[0], x1[0]};
    we_nxt = (it_d.op == bir_pkg::OP_STORE) &&
             (32'(it_d.col) < MAX_SOURCE_WIDTH) && (32'(it_d.row) < MAX_SOURCE_HEIGHT);
    for (int b = 0; b < 4; b++) begin
      if (it_d.op == bir_pkg::OP_STORE) begin
        addr_nxt[b] = bank_addr(it_d.row, it_d.col);
      end else begin
        addr_nxt[b] = bank_addr((y0[0] == b[1]) ? y0 : y1, (x0[0] == b[0]) ? x0 : x1);
      end
    end
  end

  logic           v_c_r;
  bir_pkg::item_t item_c_r;
  logic [WW-1:0]  w_c_r    [4];
  logic [BAW-1:0] addr_c_r [4];
  logic [1:0]     sel_c_r  [4];
  logic           we_c_r;
  logic [CW-1:0]  x0_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (adv) begin
      v_c_r <= v_p_r[DSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_c_r <= it_d;
      w_c_r    <= w_nxt;
      addr_c_r <= addr_nxt;
      sel_c_r  <= sel_nxt;
      we_c_r   <= we_nxt;
      x0_c_r   <= x0;
    end
  end

  // Bank stage: 2x2 interleave by row and column parity
  bir_pkg::pixel_t rd_m_r [4];
  logic            v_m_r;
  bir_pkg::item_t  item_m_r;
  logic [WW-1:0]   w_m_r   [4];
  logic [1:0]      sel_m_r [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bir_pkg::pixel_t mem [BANK_DEPTH];
    logic            wr_hit;
    assign wr_hit = we_c_r && ({item_c_r.row[0], item_c_r.col[0]} == 2'(b));

    always_ff @(posedge clk) begin
      if (adv && v_c_r) begin
        if (wr_hit) begin
          mem[addr_c_r[b]] <= item_c_r.pix;
        end
        rd_m_r[b] <= mem[addr_c_r[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_m_r <= 1'b0;
    end else if (adv) begin
      v_m_r <= v_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_m_r <= item_c_r;
      w_m_r    <= w_c_r;
      sel_m_r  <= sel_c_r;
    end
  end

  // Multiply stage: each channel of each neighbor times its weight
  logic [PW-1:0] prod_nxt [3][4];
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      prod_nxt[0][n] = rd_m_r[sel_m_r[n]].blue  * w_m_r[n];
      prod_nxt[1][n] = rd_m_r[sel_m_r[n]].green * w_m_r[n];
      prod_nxt[2][n] = rd_m_r[sel_m_r[n]].red   * w_m_r[n];
    end
  end

  logic           v_x_r;
  bir_pkg::item_t item_x_r;
  logic [PW-1:0]  prod_x_r [3][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_x_r <= 1'b0;
    end else if (adv) begin
      v_x_r <= v_m_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_x_r <= item_m_r;
      prod_x_r <= prod_nxt;
    end
  end

  // Sum stage into the output register; truncate to 8 bits
  logic [SUMW-1:0] sum_nxt [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = SUMW'(prod_x_r[c][0]) + SUMW'(prod_x_r[c][1])
                 + SUMW'(prod_x_r[c][2]) + SUMW'(prod_x_r[c][3]);
    end
  end

  logic                      out_valid_r;
  logic [bir_pkg::CHAN_W-1:0] red_r, green_r, blue_r;
  logic                      err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_x_r && (item_x_r.op == bir_pkg::OP_REQUEST);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_r   <= item_x_r.err;
      blue_r  <= item_x_r.err ? '0 : sum_nxt[0][2*F +: bir_pkg::CHAN_W];
      green_r <= item_x_r.err ? '0 : sum_nxt[1][2*F +: bir_pkg::CHAN_W];
      red_r   <= item_x_r.err ? '0 : sum_nxt[2][2*F +: bir_pkg::CHAN_W];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_out     = red_r;
  assign out_green_out   = green_r;
  assign out_blue_out    = blue_r;
  assign out_range_error = err_r;

  // Checks
  `BIR_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && out_range_error,
    (out_red_out == '0) && (out_green_out == '0) && (out_blue_out == '0))
  `BIR_ASSERT_NOW(a_div_rem, clk, rst_n,
    v_p_r[DSTEPS] && (item_p_r[DSTEPS].op == bir_pkg::OP_REQUEST) && !item_p_r[DSTEPS].err,
    (remx_p_r[DSTEPS] < dst_w_r) && (remy_p_r[DSTEPS] < dst_h_r))
  `BIR_ASSERT_NOW(a_col_clamp, clk, rst_n,
    v_c_r && (item_c_r.op == bir_pkg::OP_REQUEST), x0_c_r < sw_c)
  `BIR_ASSERT_NEXT(a_stall_hold, clk, rst_n, !adv, $stable(v_c_r) && $stable(v_m_r))

endmodule

/* test/testbench.sv */
// Testbench for the bilinear resize unit: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned STORE_W   = bir_pkg::DEF_MAX_SOURCE_WIDTH;
  localparam int unsigned STORE_H   = bir_pkg::DEF_MAX_SOURCE_HEIGHT;
  localparam int unsigned FRAC      = bir_pkg::DEF_FRACTION_BITS;
  localparam int unsigned DRAIN_GAP = 40;      // pipeline is 31 deep
  localparam int unsigned STALL_MAX = 5000;    // cycles without any item moving
  localparam logic [bir_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd5;
  localparam logic [bir_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  // Directed row kinds
  localparam int unsigned ROW_NONE  = 0;
  localparam int unsigned ROW_FIXED = 1;
  localparam int unsigned ROW_PRED  = 2;

  typedef struct packed {
    logic [bir_pkg::CHAN_W-1:0] red;
    logic [bir_pkg::CHAN_W-1:0] green;
    logic [bir_pkg::CHAN_W-1:0] blue;
    logic                       err;
  } resized_pixel_t;

  typedef struct {
    bir_pkg::op_t                op;
    logic [bir_pkg::COORD_W-1:0] col;
    logic [bir_pkg::COORD_W-1:0] row;
    logic [bir_pkg::CHAN_W-1:0]  b, g, r;
    int unsigned                 kind;
    resized_pixel_t              res;
  } stim_row_t;

  typedef struct {
    logic [bir_pkg::CFG_DATA_W-1:0] sw, sh, tw, th;
    int unsigned                    count;
  } phase_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_op;
  logic [bir_pkg::COORD_W-1:0]    in_col;
  logic [bir_pkg::COORD_W-1:0]    in_row;
  logic [bir_pkg::CHAN_W-1:0]     in_blue_in;
  logic [bir_pkg::CHAN_W-1:0]     in_green_in;
  logic [bir_pkg::CHAN_W-1:0]     in_red_in;
  logic                           out_valid;
  logic                           out_ready;
  logic [bir_pkg::CHAN_W-1:0]     out_red_out;
  logic [bir_pkg::CHAN_W-1:0]     out_green_out;
  logic [bir_pkg::CHAN_W-1:0]     out_blue_out;
  logic                           out_range_error;
  logic                           cfg_we;
  logic [bir_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bir_pkg::CFG_DATA_W-1:0] cfg_data;

  bilinear_image_resize_unit dut (.*);

  // Shadow of the block's state
  logic [23:0]                    frame_mem [STORE_W*STORE_H];
  logic [bir_pkg::SRC_SIZE_W-1:0] src_w, src_h;
  logic [bir_pkg::DST_SIZE_W-1:0] dst_w, dst_h;

  resized_pixel_t pending_pixels[$];
  int unsigned    error_count;
  int unsigned    quiet_cycles;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int unsigned eff_size(input logic [bir_pkg::SRC_SIZE_W-1:0] v,
                                           input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Bilinear interpolation of one output pixel from the shadow store
  function automatic resized_pixel_t interpolate(input logic [bir_pkg::COORD_W-1:0] col,
                                                 input logic [bir_pkg::COORD_W-1:0] row);
    resized_pixel_t    o;
    longint unsigned   sw, sh, nx, ny, fx, fy, w00, w01, w10, w11, acc, one;
    int unsigned       x0, y0, x1, y1;
    logic [23:0]       p00, p01, p10, p11;
    o = '0;
    if (col >= dst_w || row >= dst_h) begin
      o.err = 1'b1;
      return o;
    end
    one = longint'(1) << FRAC;
    sw = eff_size(src_w, STORE_W);
    sh = eff_size(src_h, STORE_H);
    nx = longint'(col) * sw;
    ny = longint'(row) * sh;
    x0 = nx / dst_w;
    y0 = ny / dst_h;
    fx = ((nx % dst_w) << FRAC) / dst_w;
    fy = ((ny % dst_h) << FRAC) / dst_h;
    if (x0 > sw - 1) x0 = sw - 1;
    if (y0 > sh - 1) y0 = sh - 1;
    x1 = (x0 < sw - 1) ? x0 + 1 : x0;
    y1 = (y0 < sh - 1) ? y0 + 1 : y0;
    w00 = (one - fx) * (one - fy);
    w01 = fx * (one - fy);
    w10 = (one - fx) * fy;
    w11 = fx * fy;
    p00 = frame_mem[y0*STORE_W + x0];
    p01 = frame_mem[y0*STORE_W + x1];
    p10 = frame_mem[y1*STORE_W + x0];
    p11 = frame_mem[y1*STORE_W + x1];
    for (int c = 0; c < 3; c++) begin
      acc = p00[8*c +: 8] * w00 + p01[8*c +: 8] * w01
          + p10[8*c +: 8] * w10 + p11[8*c +: 8] * w11;
      case (c)
        0: o.blue  = acc[2*FRAC +: 8];
        1: o.green = acc[2*FRAC +: 8];
        default: o.red = acc[2*FRAC +: 8];
      endcase
    end
    return o;
  endfunction

  // Register write at a falling edge, held for one cycle
  task automatic cfg_write(input logic [bir_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bir_pkg::CFG_DATA_W-1:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      bir_pkg::CFG_SOURCE_WIDTH:  src_w = val[bir_pkg::SRC_SIZE_W-1:0];
      bir_pkg::CFG_SOURCE_HEIGHT: src_h = val[bir_pkg::SRC_SIZE_W-1:0];
      bir_pkg::CFG_TARGET_WIDTH:  dst_w = val;
      bir_pkg::CFG_TARGET_HEIGHT: dst_h = val;
      default: ;
    endcase
  endtask

  // Offer one item; called at a falling edge, returns at a falling edge
  task automatic send_item(input bir_pkg::op_t op, input logic [bir_pkg::COORD_W-1:0] col,
                           input logic [bir_pkg::COORD_W-1:0] row,
                           input logic [bir_pkg::CHAN_W-1:0] b,
                           input logic [bir_pkg::CHAN_W-1:0] g,
                           input logic [bir_pkg::CHAN_W-1:0] r,
                           input bit fixed, input resized_pixel_t fixed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    in_op       = op;
    in_col      = col;
    in_row      = row;
    in_blue_in  = b;
    in_green_in = g;
    in_red_in   = r;
    do @(posedge clk); while (!in_ready);
    if (op == bir_pkg::OP_STORE) begin
      if (col < STORE_W && row < STORE_H) frame_mem[row*STORE_W + col] = {r, g, b};
    end else if (fixed) begin
      pending_pixels.push_back(fixed_res);
    end else begin
      pending_pixels.push_back(interpolate(col, row));
    end
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker
  always @(posedge clk) begin
    resized_pixel_t exp_px;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_red_out !== exp_px.red)
          report_mismatch($sformatf("red %0h exp %0h", out_red_out, exp_px.red));
        if (out_green_out !== exp_px.green)
          report_mismatch($sformatf("green %0h exp %0h", out_green_out, exp_px.green));
        if (out_blue_out !== exp_px.blue)
          report_mismatch($sformatf("blue %0h exp %0h", out_blue_out, exp_px.blue));
        if (out_range_error !== exp_px.err)
          report_mismatch($sformatf("range_error %0b exp %0b", out_range_error, exp_px.err));
      end
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t      dir_rows[$];
    phase_t         phases[$];
    resized_pixel_t none_px;
    resized_pixel_t err_px;
    int unsigned    swe, she, pick;
    logic [bir_pkg::COORD_W-1:0] c, r;

    error_count   = 0;
    quiet_cycles  = 0;
    send_idle_pct = 15;
    recv_idle_pct = 60;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_op       = bir_pkg::OP_STORE;
    in_col      = '0;
    in_row      = '0;
    in_blue_in  = '0;
    in_green_in = '0;
    in_red_in   = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = bir_pkg::CFG_SOURCE_WIDTH;
    cfg_data    = '0;
    src_w = bir_pkg::RST_SOURCE_WIDTH;
    src_h = bir_pkg::RST_SOURCE_HEIGHT;
    dst_w = bir_pkg::RST_TARGET_WIDTH;
    dst_h = bir_pkg::RST_TARGET_HEIGHT;
    none_px = '0;
    err_px  = '0;
    err_px.err = 1'b1;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset sizes, range errors, ignored stores, exact corner pixel
    dir_rows = '{
      '{bir_pkg::OP_REQUEST, 10'd320, 10'd0, 8'h00, 8'h00, 8'h00, ROW_FIXED, err_px},
      '{bir_pkg::OP_REQUEST, 10'd0, 10'd320, 8'hff, 8'hff, 8'hff, ROW_FIXED, err_px},
      '{bir_pkg::OP_REQUEST, 10'd1023, 10'd1023, 8'h00, 8'h00, 8'h00, ROW_FIXED, err_px},
      '{bir_pkg::OP_STORE, 10'd1023, 10'd1023, 8'hff, 8'hff, 8'hff, ROW_NONE, none_px},
      '{bir_pkg::OP_STORE, 10'd512, 10'd0, 8'h11, 8'h22, 8'h33, ROW_NONE, none_px},
      '{bir_pkg::OP_STORE, 10'd0, 10'd512, 8'h44, 8'h55, 8'h66, ROW_NONE, none_px},
      '{bir_pkg::OP_STORE, 10'd0, 10'd0, 8'hff, 8'h00, 8'h80, ROW_NONE, none_px},
      '{bir_pkg::OP_STORE, 10'd1, 10'd0, 8'h12, 8'h34, 8'h56, ROW_NONE, none_px},
      '{bir_pkg::OP_STORE, 10'd0, 10'd1, 8'h9a, 8'hbc, 8'hde, ROW_NONE, none_px},
      '{bir_pkg::OP_STORE, 10'd1, 10'd1, 8'hff, 8'hff, 8'hff, ROW_NONE, none_px},
      '{bir_pkg::OP_REQUEST, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00, ROW_FIXED,
        resized_pixel_t'({8'h80, 8'h00, 8'hff, 1'b0})},
      '{bir_pkg::OP_STORE, 10'd0, 10'd0, 8'h00, 8'hff, 8'h00, ROW_NONE, none_px},
      '{bir_pkg::OP_REQUEST, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00, ROW_FIXED,
        resized_pixel_t'({8'h00, 8'hff, 8'h00, 1'b0})},
      '{bir_pkg::OP_STORE, 10'd0, 10'd0, 8'hff, 8'hff, 8'hff, ROW_NONE, none_px},
      '{bir_pkg::OP_REQUEST, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00, ROW_PRED, none_px},
      '{bir_pkg::OP_REQUEST, 10'd319, 10'd320, 8'h00, 8'h00, 8'h00, ROW_PRED, none_px}
    };
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].col, dir_rows[i].row, dir_rows[i].b,
                dir_rows[i].g, dir_rows[i].r, dir_rows[i].kind == ROW_FIXED,
                dir_rows[i].res);
    drain();

    // Random phases: source size, target size, item count
    phases = '{
      '{11'd4, 11'd4, 11'd7, 11'd5, 60},
      '{11'd0, 11'd3, 11'd1, 11'd9, 40},
      '{11'h7ff, 11'd1, 11'd1024, 11'd3, 60},
      '{11'd1, 11'd6, 11'd2, 11'd2047, 60},
      '{11'd16, 11'd16, 11'd5, 11'd3, 60},
      '{11'd2, 11'd2, 11'd1024, 11'd1024, 60},
      '{11'd24, 11'd1, 11'd0, 11'd4, 40},
      '{11'd3, 11'd5, 11'd3, 11'd5, 60},
      '{11'd8, 11'd8, 11'd2047, 11'd2047, 60},
      '{11'd5, 11'd7, 11'd13, 11'd0, 40}
    };
    foreach (phases[p]) begin
      if (p >= 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (p >= 4) begin
        send_idle_pct = 60;
        recv_idle_pct = 15;
      end
      if (p == 4) begin
        cfg_write(CFG_SPARE_A, 11'($urandom));
        cfg_write(CFG_SPARE_B, 11'($urandom));
      end
      cfg_write(bir_pkg::CFG_SOURCE_WIDTH, phases[p].sw);
      cfg_write(bir_pkg::CFG_SOURCE_HEIGHT, phases[p].sh);
      cfg_write(bir_pkg::CFG_TARGET_WIDTH, phases[p].tw);
      cfg_write(bir_pkg::CFG_TARGET_HEIGHT, phases[p].th);
      swe = eff_size(src_w, STORE_W);
      she = eff_size(src_h, STORE_H);

      // Fill the whole source region so no request reads an unwritten entry
      for (int y = 0; y < she; y++)
        for (int x = 0; x < swe; x++)
          send_item(bir_pkg::OP_STORE, bir_pkg::COORD_W'(x), bir_pkg::COORD_W'(y),
                    8'($urandom), 8'($urandom), 8'($urandom), 1'b0, none_px);

      for (int n = 0; n < phases[p].count; n++) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          // overwrite inside the region
          send_item(bir_pkg::OP_STORE, bir_pkg::COORD_W'($urandom_range(swe - 1)),
                    bir_pkg::COORD_W'($urandom_range(she - 1)), 8'($urandom),
                    8'($urandom), 8'($urandom), 1'b0, none_px);
        end else if (pick < 15) begin
          // store outside the frame store, ignored
          c = 10'($urandom);
          r = 10'($urandom);
          if ($urandom_range(1)) c[9] = 1'b1;
          else r[9] = 1'b1;
          send_item(bir_pkg::OP_STORE, c, r, 8'($urandom), 8'($urandom), 8'($urandom),
                    1'b0, none_px);
        end else if (pick < 25 || dst_w == 0 || dst_h == 0) begin
          // any coordinate, mostly out of range
          send_item(bir_pkg::OP_REQUEST, 10'($urandom), 10'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom), 1'b0, none_px);
        end else begin
          c = (dst_w > 1024) ? 10'($urandom) : bir_pkg::COORD_W'($urandom_range(dst_w - 1));
          r = (dst_h > 1024) ? 10'($urandom) : bir_pkg::COORD_W'($urandom_range(dst_h - 1));
          send_item(bir_pkg::OP_REQUEST, c, r, 8'($urandom), 8'($urandom), 8'($urandom),
                    1'b0, none_px);
        end
      end
      drain();
    end

    if (error_count == 0 && pending_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
